// ----- src/bbeq_pkg.sv -----
// shared types and constants of the break-beam event qualifier
// no dependencies
`default_nettype none

package bbeq_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SensorW = 5;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0]   BlipTimeReset   = 32'd1000;
  localparam logic [TimeW-1:0]   SettleTimeReset = 32'd60000;
  localparam logic [SensorW-1:0] SensorIdReset   = 5'd0;

  // edge kinds carried by an input transaction
  typedef enum logic [OpW-1:0] {
    OP_FALL      = 2'd0,
    OP_RISE      = 2'd1,
    OP_FALL_RISE = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BLIP_TIME   = 2'd0,
    REG_SETTLE_TIME = 2'd1,
    REG_SENSOR_ID   = 2'd2
  } reg_idx_t;

  // beam tracking states
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_EVENT    = 4'b0010,
    ST_REPORTED = 4'b0100,
    ST_MAYBE    = 4'b1000
  } beam_state_t;

  typedef struct packed {
    logic [TimeW-1:0] blip_time;
    logic [TimeW-1:0] settle_time;
  } timing_cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [TimeW-1:0] edge_time;
  } edge_item_t;

  typedef struct packed {
    logic             emit;
    logic [TimeW-1:0] began_at;
  } qual_result_t;

endpackage

`default_nettype wire

// ----- src/bbeq_core.sv -----
// beam state machine: applies one edge per step and flags a qualified event
// depends on bbeq_pkg
`default_nettype none

module bbeq_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire bbeq_pkg::edge_item_t item,
  input  wire bbeq_pkg::timing_cfg_t cfg,
  output bbeq_pkg::qual_result_t    result
);
  import bbeq_pkg::*;

  beam_state_t      state, state_next, state_mid;
  logic [TimeW-1:0] last_restore_time, last_restore_time_next;
  logic [TimeW-1:0] event_start_time, event_start_time_next, start_mid;
  logic [TimeW-1:0] gap_rise, gap_event, held;
  logic             do_break, do_restore;

  assign do_break   = (item.operation == OP_FALL) || (item.operation == OP_FALL_RISE);
  assign do_restore = (item.operation == OP_RISE) || (item.operation == OP_FALL_RISE);

  assign gap_rise  = item.edge_time - last_restore_time;
  assign gap_event = item.edge_time - event_start_time;

  // break half
  always_comb begin
    state_mid = state;
    start_mid = event_start_time;
    if (do_break) begin
      unique case (state)
        ST_IDLE: begin
          if (gap_event < cfg.settle_time) begin
            state_mid = ST_REPORTED;
          end else begin
            state_mid = ST_EVENT;
            start_mid = item.edge_time;
          end
        end
        ST_MAYBE: begin
          if (gap_rise >= cfg.blip_time) begin
            start_mid = item.edge_time;
          end
          state_mid = ST_EVENT;
        end
        default: ;
      endcase
    end
  end

  assign held = item.edge_time - start_mid;

  // restore half
  always_comb begin
    state_next             = state_mid;
    event_start_time_next  = start_mid;
    last_restore_time_next = last_restore_time;
    result.emit            = 1'b0;
    result.began_at        = start_mid;
    if (do_restore) begin
      last_restore_time_next = item.edge_time;
      unique case (state_mid)
        ST_EVENT: begin
          if (held < cfg.blip_time) begin
            state_next = ST_MAYBE;
          end else begin
            state_next  = ST_IDLE;
            result.emit = 1'b1;
          end
        end
        ST_REPORTED: state_next = ST_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      last_restore_time <= '0;
      event_start_time  <= '0;
    end else if (step) begin
      state             <= state_next;
      last_restore_time <= last_restore_time_next;
      event_start_time  <= event_start_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/break_beam_event_qualifier_unit.sv -----
// top level of the break-beam event qualifier: input register, config, result register
// depends on bbeq_pkg and bbeq_core
`default_nettype none

//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   operation, edge_time
//  event     out        event_valid / event_stall sensor_number, began_at, ended_at
//  config    in         cfg_write                 cfg_index, cfg_data
//
// one edge per cycle while item_stall is low: an edge is captured in the input register,
// then the state machine update and the event decision are made from the held edge
// when it advances, and a qualifying event is loaded into the result register
// rst is synchronous: clears the beam state, both timestamps, the config registers
// (to their defaults) and both pipeline valids
// event_stall holds the result register; edges that make no event still drain,
// item_stall rises only while the held edge makes an event and a stalled one waits

module break_beam_event_qualifier_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [bbeq_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bbeq_pkg::TimeW-1:0]    cfg_data,
  // edge input
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [bbeq_pkg::OpW-1:0]      operation,
  input  wire logic [bbeq_pkg::TimeW-1:0]    edge_time,
  // qualified event output
  output logic                               event_valid,
  input  wire logic                          event_stall,
  output logic [bbeq_pkg::SensorW-1:0]       sensor_number,
  output logic [bbeq_pkg::TimeW-1:0]         began_at,
  output logic [bbeq_pkg::TimeW-1:0]         ended_at
);
  import bbeq_pkg::*;

  // configuration registers
  logic [TimeW-1:0]   blip_time;
  logic [TimeW-1:0]   settle_time;
  logic [SensorW-1:0] sensor_id;
  timing_cfg_t        timing;

  // input register stage
  logic         held_valid;
  edge_item_t   held_item;
  logic         advance;
  logic         accept;
  qual_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      blip_time   <= BlipTimeReset;
      settle_time <= SettleTimeReset;
      sensor_id   <= SensorIdReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLIP_TIME:   blip_time   <= cfg_data;
        REG_SETTLE_TIME: settle_time <= cfg_data;
        REG_SENSOR_ID:   sensor_id   <= cfg_data[SensorW-1:0];
        default: ;
      endcase
    end
  end

  assign timing.blip_time   = blip_time;
  assign timing.settle_time = settle_time;

  // the held edge moves on when the result register can take it, or when it
  // makes no event at all
  assign advance    = held_valid && (!event_valid || !event_stall || !result.emit);
  assign item_stall = held_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.operation <= operation;
      held_item.edge_time <= edge_time;
    end
  end

  bbeq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .cfg    (timing),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && result.emit) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      sensor_number <= sensor_id;
      began_at      <= result.began_at;
      ended_at      <= held_item.edge_time;
    end
  end

endmodule

`default_nettype wire

// ----- src/bbeq_checker.sv -----
// port-level checks for the break-beam event qualifier, bound to the top level
// depends on bbeq_pkg
`default_nettype none

module bbeq_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_valid,
  input wire logic                         item_stall,
  input wire logic                         event_valid,
  input wire logic                         event_stall,
  input wire logic [bbeq_pkg::SensorW-1:0] sensor_number,
  input wire logic [bbeq_pkg::TimeW-1:0]   began_at,
  input wire logic [bbeq_pkg::TimeW-1:0]   ended_at
);
  import bbeq_pkg::*;

  // a stalled event keeps its payload
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(sensor_number)
      && $stable(began_at) && $stable(ended_at))
    else $error("stalled event transaction changed");

  // input back-pressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> event_valid && event_stall)
    else $error("item stalled while output free");

  // output register is empty right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !event_valid)
    else $error("event valid right after reset");

endmodule

bind break_beam_event_qualifier_unit bbeq_checker u_bbeq_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .event_valid   (event_valid),
  .event_stall   (event_stall),
  .sensor_number (sensor_number),
  .began_at      (began_at),
  .ended_at      (ended_at)
);

`default_nettype wire

// ----- test/bbeq_event_checker.sv -----
// watches the config, edge and event channels of break_beam_event_qualifier_unit,
// predicts every qualified event and compares it field by field with what comes out
// depends on bbeq_pkg
module bbeq_event_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bbeq_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bbeq_pkg::TimeW-1:0]   cfg_data,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  logic [bbeq_pkg::OpW-1:0]     operation,
  input  logic [bbeq_pkg::TimeW-1:0]   edge_time,
  input  logic                         event_valid,
  input  logic                         event_stall,
  input  logic [bbeq_pkg::SensorW-1:0] sensor_number,
  input  logic [bbeq_pkg::TimeW-1:0]   began_at,
  input  logic [bbeq_pkg::TimeW-1:0]   ended_at,
  output int                           mismatches,
  output int                           events_owed
);
  import bbeq_pkg::*;

  typedef struct packed {
    logic [SensorW-1:0] sensor;
    logic [TimeW-1:0]   start_us;
    logic [TimeW-1:0]   stop_us;
  } qual_event_t;

  // shadow of the block's registers and beam tracking
  logic [TimeW-1:0]   blip_us;
  logic [TimeW-1:0]   settle_us;
  logic [SensorW-1:0] sensor_reg;
  beam_state_t        beam;
  logic [TimeW-1:0]   last_rise_us;
  logic [TimeW-1:0]   event_start_us;

  qual_event_t owed_q[$];
  int          fail_tally = 0;
  int          owed_n = 0;

  assign mismatches  = fail_tally;
  assign events_owed = owed_n;

  // beam broken
  task automatic apply_break(input logic [TimeW-1:0] t);
    logic [TimeW-1:0] since_rise;
    logic [TimeW-1:0] since_start;
    since_rise  = t - last_rise_us;
    since_start = t - event_start_us;
    case (beam)
      ST_IDLE: begin
        if (since_start < settle_us) begin
          beam = ST_REPORTED;
        end else begin
          event_start_us = t;
          beam = ST_EVENT;
        end
      end
      ST_MAYBE: begin
        if (since_rise >= blip_us) event_start_us = t;
        beam = ST_EVENT;
      end
      default: ;
    endcase
  endtask

  // beam restored, may owe one event
  task automatic apply_restore(input logic [TimeW-1:0] t);
    logic [TimeW-1:0] held;
    qual_event_t      ev;
    held = t - event_start_us;
    last_rise_us = t;
    case (beam)
      ST_EVENT: begin
        if (held < blip_us) begin
          beam = ST_MAYBE;
        end else begin
          beam = ST_IDLE;
          ev = '{sensor_reg, event_start_us, t};
          owed_q.insert(owed_q.size(), ev);
        end
      end
      ST_REPORTED: beam = ST_IDLE;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    qual_event_t want;
    if (rst) begin
      blip_us        = BlipTimeReset;
      settle_us      = SettleTimeReset;
      sensor_reg     = SensorIdReset;
      beam           = ST_IDLE;
      last_rise_us   = '0;
      event_start_us = '0;
      owed_q.delete();
    end else begin
      // compare first: a result shown now never belongs to an edge taken now
      if (event_valid && !event_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected event: sensor_number %0d began_at %0d ended_at %0d",
                 sensor_number, began_at, ended_at);
          fail_tally++;
        end else begin
          want = owed_q.pop_front();
          if (sensor_number !== want.sensor) begin
            $error("sensor_number: expected %0d, actual %0d", want.sensor, sensor_number);
            fail_tally++;
          end
          if (began_at !== want.start_us) begin
            $error("began_at: expected %0d, actual %0d", want.start_us, began_at);
            fail_tally++;
          end
          if (ended_at !== want.stop_us) begin
            $error("ended_at: expected %0d, actual %0d", want.stop_us, ended_at);
            fail_tally++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BLIP_TIME:   blip_us    = cfg_data;
          REG_SETTLE_TIME: settle_us  = cfg_data;
          REG_SENSOR_ID:   sensor_reg = cfg_data[SensorW-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        case (operation)
          OP_FALL: apply_break(edge_time);
          OP_RISE: apply_restore(edge_time);
          OP_FALL_RISE: begin
            apply_break(edge_time);
            apply_restore(edge_time);
          end
          default: ;
        endcase
      end
    end
    owed_n = owed_q.size();
  end

endmodule

// ----- test/break_beam_event_qualifier_unit_tb.sv -----
// top of the break-beam event qualifier testbench: clock, reset, config writes,
// edge stimulus, event back-pressure and the verdict
// depends on bbeq_pkg, break_beam_event_qualifier_unit and bbeq_event_checker
module break_beam_event_qualifier_unit_tb;
  import bbeq_pkg::*;

  // hard stop, far beyond the slowest legal run
  localparam int CycleLimit = 400000;
  // long receiver hold-off used to back the block up into its input
  localparam int HoldCycles = 120;
  // quiet cycles after the last owed event, so that in-flight edges can retire
  localparam int QuietCycles = 8;
  // op code and register index outside the defined sets
  localparam logic [OpW-1:0]     OpUnused     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_BLIP_TIME;
  logic [TimeW-1:0]   cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [OpW-1:0]     operation = OP_FALL;
  logic [TimeW-1:0]   edge_time = '0;
  logic               event_valid;
  logic               event_stall = 1'b0;
  logic [SensorW-1:0] sensor_number;
  logic [TimeW-1:0]   began_at;
  logic [TimeW-1:0]   ended_at;

  int mismatches;
  int events_owed;

  // idling percentages, set per phase by the stimulus process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // hold-off requests: raised by the stimulus, served by the receiver
  int hold_asks = 0;
  int hold_done = 0;
  int cycles = 0;

  // running microsecond clock of the sensor and what the beam last did
  logic [TimeW-1:0] now = '0;
  bit               beam_down = 1'b0;
  // timing registers as last written, used to aim the gaps
  logic [TimeW-1:0] blip_cur = BlipTimeReset;
  logic [TimeW-1:0] settle_cur = SettleTimeReset;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  break_beam_event_qualifier_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .edge_time(edge_time),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .sensor_number(sensor_number),
    .began_at(began_at),
    .ended_at(ended_at)
  );

  bbeq_event_checker event_check (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .edge_time(edge_time),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .sensor_number(sensor_number),
    .began_at(began_at),
    .ended_at(ended_at),
    .mismatches(mismatches),
    .events_owed(events_owed)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // event receiver: random stall per cycle, or a long hold-off when asked
  initial begin : event_receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_done != hold_asks) begin
        hold_done = hold_done + 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        event_stall = 1'b1;
        hold_left = hold_left - 1;
      end else begin
        event_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one edge transaction: optional idle cycles, then hold until taken
  task automatic offer_edge(input logic [OpW-1:0] op, input logic [TimeW-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    operation  = op;
    edge_time  = t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // stop offering, wait for every owed event, then let in-flight edges retire
  task automatic drain_block();
    @(negedge clk);
    item_valid = 1'b0;
    while (events_owed != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_timing(input logic [TimeW-1:0] blip, input logic [TimeW-1:0] settle,
                            input logic [TimeW-1:0] sensor);
    write_reg(REG_BLIP_TIME, blip);
    write_reg(REG_SETTLE_TIME, settle);
    write_reg(REG_SENSOR_ID, sensor);
    blip_cur   = blip;
    settle_cur = settle;
  endtask

  // gap to the next edge, aimed at the blip and settle thresholds
  function automatic logic [TimeW-1:0] pick_gap();
    case ($urandom_range(9))
      0:       return $urandom_range(3);
      1, 2:    return blip_cur - 32'd1 + $urandom_range(2);
      3, 4:    return $urandom_range(blip_cur);
      5, 6:    return settle_cur - 32'd1 + $urandom_range(2);
      7:       return $urandom_range(settle_cur);
      8:       return settle_cur + blip_cur + $urandom_range(1000);
      default: return $urandom();
    endcase
  endfunction

  // mostly alternating fall/rise with random timing, some fall-rise pairs,
  // some repeated edges and a few unused op codes as noise
  task automatic run_random(input int count);
    int taken;
    int pick;
    logic [OpW-1:0] op;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(99);
      now  = now + pick_gap();
      if (pick < 5) op = OpUnused;
      else if (pick < 13) op = OP_FALL_RISE;
      else if (pick < 20) op = beam_down ? OP_FALL : OP_RISE;
      else op = beam_down ? OP_RISE : OP_FALL;
      offer_edge(op, now);
      if (op == OP_FALL) beam_down = 1'b1;
      else if (op != OpUnused) beam_down = 1'b0;
      if (op != OpUnused) taken++;
    end
  endtask

  // long events back to back while the receiver holds off: the result
  // register fills and the block has to stall its edge input
  task automatic flood_while_held();
    int k;
    hold_asks = hold_asks + 1;
    for (k = 0; k < 12; k++) begin
      now = now + settle_cur + blip_cur + 32'd1;
      offer_edge(OP_FALL, now);
      now = now + blip_cur + 32'd5;
      offer_edge(OP_RISE, now);
    end
    beam_down = 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    logic [TimeW-1:0] b;
    logic [TimeW-1:0] s;
    logic [TimeW-1:0] id;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 46;

    // directed part with the reset timing (blip 1000, settle 60000)
    // a break right after reset lies within settle of start 0: merged, no event
    offer_edge(OP_FALL, 32'd0);
    offer_edge(OP_RISE, 32'd10);
    // rise while idle only moves the restore time
    offer_edge(OP_RISE, 32'd500);
    // short break, short gap, joined into one event
    offer_edge(OP_FALL, 32'd100000);
    offer_edge(OP_RISE, 32'd100500);
    offer_edge(OP_FALL, 32'd100800);
    offer_edge(OP_RISE, 32'd102000);
    // new break inside settle of the last start: merged
    offer_edge(OP_FALL, 32'd110000);
    offer_edge(OP_RISE, 32'd111000);
    // fall while in an event changes nothing; held exactly blip reports
    offer_edge(OP_FALL, 32'd200000);
    offer_edge(OP_FALL, 32'd200100);
    offer_edge(OP_RISE, 32'd201000);
    // blip, rise during maybe, then a break after a long gap restarts the event
    offer_edge(OP_FALL, 32'd300000);
    offer_edge(OP_RISE, 32'd300999);
    offer_edge(OP_RISE, 32'd301500);
    offer_edge(OP_FALL, 32'd303000);
    offer_edge(OP_RISE, 32'd305000);
    // unused op code is ignored
    offer_edge(OpUnused, 32'd400000);
    // fall-rise with nonzero blip ends as a maybe
    offer_edge(OP_FALL_RISE, 32'd500000);
    // event across the timestamp wrap, from the all-ones time
    offer_edge(OP_FALL, 32'hFFFF_FFFF);
    offer_edge(OP_RISE, 32'h0000_03FF);
    offer_edge(OP_FALL_RISE, 32'h8000_0000);
    // with blip zero a fall-rise reports on its own
    drain_block();
    write_reg(REG_BLIP_TIME, 32'd0);
    blip_cur = 32'd0;
    offer_edge(OP_FALL_RISE, 32'h9000_0000);
    now = 32'h9000_0000;

    // random phases over several timing settings, extremes included
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin b = 32'd1000;       s = 32'd60000;      id = 32'd7;          end
        1:       begin b = 32'd0;          s = 32'd0;          id = 32'd29;         end
        2:       begin b = 32'hFFFF_FFFF;  s = 32'hFFFF_FFFF;  id = 32'hFFFF_FFFF;  end
        3:       begin b = 32'd1;          s = 32'd1;          id = 32'd30;         end
        4:       begin b = $urandom_range(1, 5000); s = $urandom_range(200000); id = $urandom(); end
        5:       begin b = 32'd5000;       s = 32'hFFFF_FFFF;  id = 32'd0;          end
        6:       begin b = 32'd0;          s = 32'd100000;     id = 32'd16;         end
        default: begin b = $urandom();     s = $urandom();     id = $urandom();     end
      endcase
      // sender idles lightly first, then heavily, then neither side idles
      if (ph < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 46;
      end else if (ph < 6) begin
        send_idle_pct = 46;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_block();
      set_timing(b, s, id);
      if (ph == 0) write_reg(CfgIdxUnused, $urandom());

      case (ph)
        0: begin
          run_random(50);
          flood_while_held();
          run_random(100);
        end
        1: begin
          run_random(75);
          // pause the sender until every owed event has come out
          drain_block();
          run_random(75);
        end
        default: run_random(150);
      endcase
    end

    drain_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bbeq_pkg.sv
src/bbeq_core.sv
src/break_beam_event_qualifier_unit.sv
src/bbeq_checker.sv
test/bbeq_event_checker.sv
test/break_beam_event_qualifier_unit_tb.sv
